// ----- hdl/abbt_pkg.sv -----
// Types, constants and register codes shared by the box transform modules.
`timescale 1ns / 1ps
package abbt_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = COEF_W - 4;
    localparam int AXES      = 3;
    localparam int ROW_W     = AXES * COEF_W;
    localparam int CFG_W     = (ROW_W > COORD_W) ? ROW_W : COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W - COEF_FRAC;
    localparam int RES_W     = ((RND_W > COORD_W) ? RND_W : COORD_W) + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;

    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (COEF_FRAC - 1);
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM     = 3'd0,
        CFG_ROW_X   = 3'd1,
        CFG_ROW_Y   = 3'd2,
        CFG_ROW_Z   = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5,
        CFG_SHIFT_Z = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_coord x_lo;
        t_coord x_hi;
        t_coord y_lo;
        t_coord y_hi;
        t_coord z_lo;
        t_coord z_hi;
    } t_box_in;

    typedef struct packed {
        t_coord out_x_lo;
        t_coord out_x_hi;
        t_coord out_y_lo;
        t_coord out_y_hi;
        t_coord out_z_lo;
        t_coord out_z_hi;
        logic   saturated;
    } t_box_out;

    typedef struct packed {
        logic [1:0]                  dim;
        logic [AXES-1:0][ROW_W-1:0]  row;
        logic [AXES-1:0][COORD_W-1:0] shift;
    } t_cfg;

    // Ordered bounds of one box, as handed from front to back.
    typedef struct packed {
        logic                          two_d;
        logic [AXES-1:0][COORD_W-1:0]  mn;
        logic [AXES-1:0][COORD_W-1:0]  mx;
    } t_item;

endpackage

// ----- hdl/abbt_cfg.sv -----
// Configuration register file of the box transform.
`timescale 1ns / 1ps
module abbt_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [abbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abbt_pkg::CFG_W-1:0]      i_cfg_data,
    output abbt_pkg::t_cfg                  o_cfg
);

    abbt_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim <= abbt_pkg::DIM_3D;
            for (int i = 0; i < abbt_pkg::AXES; i++) begin
                r_cfg.row[i]   <= abbt_pkg::ROW_W'(abbt_pkg::COEF_ONE) << (i * abbt_pkg::COEF_W);
                r_cfg.shift[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                abbt_pkg::CFG_DIM: begin
                    // only 2 or 3 axes are legal; anything else is dropped
                    if (i_cfg_data[1:0] == abbt_pkg::DIM_2D ||
                        i_cfg_data[1:0] == abbt_pkg::DIM_3D) begin
                        r_cfg.dim <= i_cfg_data[1:0];
                    end
                end
                abbt_pkg::CFG_ROW_X:   r_cfg.row[0]   <= i_cfg_data[abbt_pkg::ROW_W-1:0];
                abbt_pkg::CFG_ROW_Y:   r_cfg.row[1]   <= i_cfg_data[abbt_pkg::ROW_W-1:0];
                abbt_pkg::CFG_ROW_Z:   r_cfg.row[2]   <= i_cfg_data[abbt_pkg::ROW_W-1:0];
                abbt_pkg::CFG_SHIFT_X: r_cfg.shift[0] <= i_cfg_data[abbt_pkg::COORD_W-1:0];
                abbt_pkg::CFG_SHIFT_Y: r_cfg.shift[1] <= i_cfg_data[abbt_pkg::COORD_W-1:0];
                abbt_pkg::CFG_SHIFT_Z: r_cfg.shift[2] <= i_cfg_data[abbt_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/abbt_front.sv -----
// Front end: takes box requests, orders the bounds per axis, masks z in 2D mode.
`timescale 1ns / 1ps
module abbt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  abbt_pkg::t_box_in i_in_data,
    input  logic              i_two_d,
    output logic              o_push,
    output abbt_pkg::t_item   o_push_item,
    input  logic              i_q_full
);

    logic            r_v;
    logic            n_v;
    abbt_pkg::t_item r_item;
    abbt_pkg::t_item n_item;
    logic            accept;
    abbt_pkg::t_coord lo [abbt_pkg::AXES];
    abbt_pkg::t_coord hi [abbt_pkg::AXES];

    assign o_in_stall  = r_v && i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_v && !i_q_full;
    assign o_push_item = r_item;

    always_comb begin
        lo[0] = i_in_data.x_lo;
        hi[0] = i_in_data.x_hi;
        lo[1] = i_in_data.y_lo;
        hi[1] = i_in_data.y_hi;
        lo[2] = i_in_data.z_lo;
        hi[2] = i_in_data.z_hi;
        n_item.two_d = i_two_d;
        for (int j = 0; j < abbt_pkg::AXES; j++) begin
            // bounds may come swapped; the corner set is the same either way
            if (lo[j] <= hi[j]) begin
                n_item.mn[j] = lo[j];
                n_item.mx[j] = hi[j];
            end else begin
                n_item.mn[j] = hi[j];
                n_item.mx[j] = lo[j];
            end
            if (i_two_d && j == abbt_pkg::AXES - 1) begin
                n_item.mn[j] = '0;
                n_item.mx[j] = '0;
            end
        end
    end

    always_comb begin
        if (accept) begin
            n_v = 1'b1;
        end else if (o_push) begin
            n_v = 1'b0;
        end else begin
            n_v = r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/abbt_queue.sv -----
// Short FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module abbt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abbt_pkg::t_item i_push_item,
    output logic            o_full,
    output logic            o_pop_valid,
    output abbt_pkg::t_item o_pop_item,
    input  logic            i_pop
);

    abbt_pkg::t_item              r_mem [abbt_pkg::QDEPTH];
    logic [abbt_pkg::QPTR_W-1:0]  r_wp;
    logic [abbt_pkg::QPTR_W-1:0]  r_rp;
    logic [abbt_pkg::QPTR_W:0]    r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full      = (r_cnt == (abbt_pkg::QPTR_W + 1)'(abbt_pkg::QDEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_item  = r_mem[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

// ----- hdl/abbt_back.sv -----
// Back end: per-axis extreme products, rounding, translation and clamping.
`timescale 1ns / 1ps
module abbt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  abbt_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  abbt_pkg::t_item    i_q_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output abbt_pkg::t_box_out o_out_data
);

    localparam int AX = abbt_pkg::AXES;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    // stage 1: products picked so that their sums give the corner extremes
    logic signed [abbt_pkg::PROD_W-1:0] r_pmin [AX][AX];
    logic signed [abbt_pkg::PROD_W-1:0] r_pmax [AX][AX];
    logic signed [abbt_pkg::PROD_W-1:0] n_pmin [AX][AX];
    logic signed [abbt_pkg::PROD_W-1:0] n_pmax [AX][AX];
    logic                               r_two_d1;

    // stage 2: rounded linear part
    logic signed [abbt_pkg::RND_W-1:0] r_rmin [AX];
    logic signed [abbt_pkg::RND_W-1:0] r_rmax [AX];
    logic signed [abbt_pkg::RND_W-1:0] n_rmin [AX];
    logic signed [abbt_pkg::RND_W-1:0] n_rmax [AX];
    logic                              r_two_d2;

    // stage 3: output register
    abbt_pkg::t_box_out r_out;
    abbt_pkg::t_box_out n_out;

    assign rdy3        = !r_v3 || !i_out_stall;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign o_pop       = i_q_valid && rdy1;
    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

    always_comb begin
        abbt_pkg::t_coef  k;
        abbt_pkg::t_coord cmn;
        abbt_pkg::t_coord cmx;
        for (int i = 0; i < AX; i++) begin
            for (int j = 0; j < AX; j++) begin
                k   = i_cfg.row[i][j*abbt_pkg::COEF_W +: abbt_pkg::COEF_W];
                cmn = i_q_item.mn[j];
                cmx = i_q_item.mx[j];
                // a negative coefficient flips which bound gives the minimum
                if (k[abbt_pkg::COEF_W-1]) begin
                    n_pmin[i][j] = abbt_pkg::PROD_W'(k) * abbt_pkg::PROD_W'(cmx);
                    n_pmax[i][j] = abbt_pkg::PROD_W'(k) * abbt_pkg::PROD_W'(cmn);
                end else begin
                    n_pmin[i][j] = abbt_pkg::PROD_W'(k) * abbt_pkg::PROD_W'(cmn);
                    n_pmax[i][j] = abbt_pkg::PROD_W'(k) * abbt_pkg::PROD_W'(cmx);
                end
            end
        end
    end

    // round to nearest, ties up: add half, then drop the coefficient fraction
    always_comb begin
        logic signed [abbt_pkg::SUM_W-1:0] smin;
        logic signed [abbt_pkg::SUM_W-1:0] smax;
        for (int i = 0; i < AX; i++) begin
            smin = abbt_pkg::RND_HALF;
            smax = abbt_pkg::RND_HALF;
            for (int j = 0; j < AX; j++) begin
                smin = smin + abbt_pkg::SUM_W'(r_pmin[i][j]);
                smax = smax + abbt_pkg::SUM_W'(r_pmax[i][j]);
            end
            n_rmin[i] = smin[abbt_pkg::SUM_W-1:abbt_pkg::COEF_FRAC];
            n_rmax[i] = smax[abbt_pkg::SUM_W-1:abbt_pkg::COEF_FRAC];
        end
    end

    always_comb begin
        logic signed [abbt_pkg::RES_W-1:0] vmin;
        logic signed [abbt_pkg::RES_W-1:0] vmax;
        logic signed [abbt_pkg::RES_W-1:0] lim_hi;
        logic signed [abbt_pkg::RES_W-1:0] lim_lo;
        abbt_pkg::t_coord qmin [AX];
        abbt_pkg::t_coord qmax [AX];
        logic sat;
        lim_hi = abbt_pkg::RES_W'(abbt_pkg::COORD_MAX);
        lim_lo = abbt_pkg::RES_W'(abbt_pkg::COORD_MIN);
        sat    = 1'b0;
        for (int i = 0; i < AX; i++) begin
            vmin = abbt_pkg::RES_W'(r_rmin[i]) +
                   abbt_pkg::RES_W'($signed(i_cfg.shift[i]));
            vmax = abbt_pkg::RES_W'(r_rmax[i]) +
                   abbt_pkg::RES_W'($signed(i_cfg.shift[i]));
            qmin[i] = vmin[abbt_pkg::COORD_W-1:0];
            qmax[i] = vmax[abbt_pkg::COORD_W-1:0];
            if (vmin < lim_lo) begin
                qmin[i] = abbt_pkg::COORD_MIN;
            end else if (vmin > lim_hi) begin
                qmin[i] = abbt_pkg::COORD_MAX;
            end
            if (vmax > lim_hi) begin
                qmax[i] = abbt_pkg::COORD_MAX;
            end else if (vmax < lim_lo) begin
                qmax[i] = abbt_pkg::COORD_MIN;
            end
            // any clipped corner drives one of the two extremes out of range
            if (!(r_two_d2 && i == AX - 1) && (vmin < lim_lo || vmax > lim_hi)) begin
                sat = 1'b1;
            end
        end
        if (r_two_d2) begin
            qmin[AX-1] = '0;
            qmax[AX-1] = '0;
        end
        n_out.out_x_lo  = qmin[0];
        n_out.out_x_hi  = qmax[0];
        n_out.out_y_lo  = qmin[1];
        n_out.out_y_hi  = qmax[1];
        n_out.out_z_lo  = qmin[2];
        n_out.out_z_hi  = qmax[2];
        n_out.saturated = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_q_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pmin   <= n_pmin;
            r_pmax   <= n_pmax;
            r_two_d1 <= i_q_item.two_d;
        end
        if (rdy2) begin
            r_rmin   <= n_rmin;
            r_rmax   <= n_rmax;
            r_two_d2 <= r_two_d1;
        end
        if (rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- hdl/affine_bounding_box_transform.sv -----
// Affine transform of an axis-aligned box: top level.
//
// Input channel: i_in_valid / o_in_stall with i_in_data carrying the six box
// bounds (signed Q16.16). A request is taken at a clock edge with valid high
// and stall low. Output channel: o_out_valid / i_out_stall with o_out_data
// carrying the transformed bounds and a saturation flag, one result per request
// in order. Configuration: i_cfg_valid / o_cfg_ready with a register index and
// data; o_cfg_ready is always high. Write registers only while no request is
// in flight.
// Path: a request passes the front register, queue, product stage, rounding
// stage and output register, in that order.
// Throughput: one request per cycle while the receiver does not stall; the 18
// coefficient multipliers in the product stage run once per request.
// When the receiver stalls, the output register holds its result, the back
// stages fill, the 4-entry queue absorbs requests, and o_in_stall rises once
// the queue and front register are full.
// Reset (synchronous, active low) empties all stages and the queue and loads
// the identity transform in 3D mode.
`timescale 1ns / 1ps
module affine_bounding_box_transform (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  abbt_pkg::t_box_in               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output abbt_pkg::t_box_out              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [abbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abbt_pkg::CFG_W-1:0]      i_cfg_data
);

    abbt_pkg::t_cfg  cfg;
    logic            push;
    abbt_pkg::t_item push_item;
    logic            q_full;
    logic            q_valid;
    abbt_pkg::t_item q_item;
    logic            pop;

    abbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_two_d     (cfg.dim == abbt_pkg::DIM_2D),
        .o_push      (push),
        .o_push_item (push_item),
        .i_q_full    (q_full)
    );

    abbt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_pop_valid (q_valid),
        .o_pop_item  (q_item),
        .i_pop       (pop)
    );

    abbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/abbt_checker.sv -----
// Port-level checks for the box transform, bound to the top level.
`timescale 1ns / 1ps
module abbt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input abbt_pkg::t_box_out o_out_data
);

    // reset empties the pipeline: nothing shown on the next cycle
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // reset empties the front register, so requests are taken at once
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // extremes over the corners are always ordered, even for swapped bounds
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_x_lo <= o_out_data.out_x_hi) &&
                        (o_out_data.out_y_lo <= o_out_data.out_y_hi) &&
                        (o_out_data.out_z_lo <= o_out_data.out_z_hi))
        else $error("result low bound above high bound");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind affine_bounding_box_transform abbt_checker u_abbt_checker (.*);

// ----- tb/abbt_box_checker.sv -----
// Checker for the box transform: tracks the registers, predicts each box and compares results.
`timescale 1ns / 1ps
module abbt_box_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  abbt_pkg::t_box_in              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  abbt_pkg::t_box_out             i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [abbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [abbt_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count,
    output int                             o_sat_count
);
    import abbt_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [1:0]         dim_reg;
    logic [ROW_W-1:0]   row_reg   [AXES];
    logic [COORD_W-1:0] shift_reg [AXES];
    t_box_out           expected_boxes [$];

    // One mapped coordinate: exact dot product, round half up to Q16.16, shift, clamp.
    function automatic longint map_coord(input int axis, input longint px, input longint py,
                                         input longint pz, input bit three_d, inout bit sat);
        longint k0, k1, k2, acc, offset, lim_hi, lim_lo;
        k0 = $signed(row_reg[axis][0 +: COEF_W]);
        k1 = $signed(row_reg[axis][COEF_W +: COEF_W]);
        k2 = $signed(row_reg[axis][2*COEF_W +: COEF_W]);
        offset = $signed(shift_reg[axis]);
        lim_hi = COORD_MAX;
        lim_lo = COORD_MIN;
        acc = k0 * px + k1 * py;
        if (three_d)
            acc = acc + k2 * pz;
        acc = (acc + (64'sd1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
        acc = acc + offset;
        if (acc > lim_hi) begin
            acc = lim_hi;
            sat = 1'b1;
        end
        if (acc < lim_lo) begin
            acc = lim_lo;
            sat = 1'b1;
        end
        return acc;
    endfunction

    function automatic t_box_out transform_box(input t_box_in box);
        t_box_out res;
        longint   lo [AXES];
        longint   hi [AXES];
        longint   mn [AXES];
        longint   mx [AXES];
        longint   px, py, pz, q;
        bit       three_d, sat;
        int       axes_used, corner, a;
        three_d   = (dim_reg == DIM_3D);
        axes_used = three_d ? 3 : 2;
        sat       = 1'b0;
        lo[0] = box.x_lo;
        hi[0] = box.x_hi;
        lo[1] = box.y_lo;
        hi[1] = box.y_hi;
        lo[2] = box.z_lo;
        hi[2] = box.z_hi;
        for (a = 0; a < AXES; a++) begin
            mn[a] = 0;
            mx[a] = 0;
        end
        for (corner = 0; corner < (1 << axes_used); corner++) begin
            px = corner[0] ? hi[0] : lo[0];
            py = corner[1] ? hi[1] : lo[1];
            pz = corner[2] ? hi[2] : lo[2];
            for (a = 0; a < axes_used; a++) begin
                q = map_coord(a, px, py, pz, three_d, sat);
                if (corner == 0 || q < mn[a]) mn[a] = q;
                if (corner == 0 || q > mx[a]) mx[a] = q;
            end
        end
        // z stays zero in 2D mode
        res.out_x_lo  = mn[0][COORD_W-1:0];
        res.out_x_hi  = mx[0][COORD_W-1:0];
        res.out_y_lo  = mn[1][COORD_W-1:0];
        res.out_y_hi  = mx[1][COORD_W-1:0];
        res.out_z_lo  = mn[2][COORD_W-1:0];
        res.out_z_hi  = mx[2][COORD_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("Mismatch on %s of result %0d: expected %h, got %h",
                         label, o_result_count, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_box_out want;
        int       a;
        if (!i_rst_n) begin
            dim_reg = DIM_3D;
            for (a = 0; a < AXES; a++) begin
                row_reg[a] = '0;
                row_reg[a][a*COEF_W +: COEF_W] = COEF_ONE;
                shift_reg[a] = '0;
            end
            expected_boxes.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_sat_count    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIM: begin
                        // only 2 and 3 are taken; anything else leaves the mode alone
                        if (i_cfg_data[1:0] == DIM_2D || i_cfg_data[1:0] == DIM_3D)
                            dim_reg = i_cfg_data[1:0];
                    end
                    CFG_ROW_X:   row_reg[0]   = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Y:   row_reg[1]   = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Z:   row_reg[2]   = i_cfg_data[ROW_W-1:0];
                    CFG_SHIFT_X: shift_reg[0] = i_cfg_data[COORD_W-1:0];
                    CFG_SHIFT_Y: shift_reg[1] = i_cfg_data[COORD_W-1:0];
                    CFG_SHIFT_Z: shift_reg[2] = i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_boxes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("Result with no request outstanding: %h", i_out_data);
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("out_x_lo", want.out_x_lo, i_out_data.out_x_lo);
                    check_field("out_x_hi", want.out_x_hi, i_out_data.out_x_hi);
                    check_field("out_y_lo", want.out_y_lo, i_out_data.out_y_lo);
                    check_field("out_y_hi", want.out_y_hi, i_out_data.out_y_hi);
                    check_field("out_z_lo", want.out_z_lo, i_out_data.out_z_lo);
                    check_field("out_z_hi", want.out_z_hi, i_out_data.out_z_hi);
                    check_field("saturated", COORD_W'(want.saturated),
                                COORD_W'(i_out_data.saturated));
                    if (want.saturated) o_sat_count++;
                end
                o_result_count++;
            end
            if (i_in_valid && !i_in_stall)
                expected_boxes.push_back(transform_box(i_in_data));
        end
        o_pending = expected_boxes.size();
    end

endmodule

// ----- tb/tb_affine_bounding_box_transform.sv -----
// Testbench top for the affine box transform: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb_affine_bounding_box_transform;
    import abbt_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PERCENT  = 14;
    localparam int STUCK_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BOXES   = 160;
    localparam int DRAIN_CYCLES  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam logic [COEF_W-1:0]    COEF_NEG_MAX = 16'h8000;
    localparam logic [COEF_W-1:0]    COEF_POS_MAX = 16'h7FFF;
    localparam logic [COEF_W-1:0]    COEF_HALF    = 16'h0800;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_box_in              i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_box_out             o_out_data;
    logic                 o_cfg_ready;

    int fail_count, pending, result_count, sat_count;
    int settings_used = 0;
    int stuck_cycles  = 0;
    bit calm          = 1'b0;
    bit in_taken      = 1'b0;
    bit cfg_taken     = 1'b0;

    affine_bounding_box_transform DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    abbt_box_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_sat_count    (sat_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // handshake outcomes of the last edge, read by the drivers at the next falling edge
    always @(posedge i_clk) begin
        in_taken  <= i_in_valid && !o_in_stall;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
    end

    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int rand_span(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return rand_span(1 << 21);
        endcase
    endfunction

    function automatic t_box_in rand_box();
        t_box_in box;
        box.x_lo = rand_coord();
        box.x_hi = rand_coord();
        box.y_lo = rand_coord();
        box.y_hi = rand_coord();
        box.z_lo = rand_coord();
        box.z_hi = rand_coord();
        return box;
    endfunction

    // coefficients within +-2.0, the range of rotations and moderate scaling
    function automatic logic [ROW_W-1:0] rand_small_row();
        return {COEF_W'(rand_span(8192)), COEF_W'(rand_span(8192)), COEF_W'(rand_span(8192))};
    endfunction

    function automatic logic [ROW_W-1:0] rand_full_row();
        return ROW_W'({$urandom, $urandom});
    endfunction

    function automatic t_box_in make_box(input t_coord xl, input t_coord xh, input t_coord yl,
                                         input t_coord yh, input t_coord zl, input t_coord zh);
        t_box_in box;
        box.x_lo = xl;
        box.x_hi = xh;
        box.y_lo = yl;
        box.y_hi = yh;
        box.z_lo = zl;
        box.z_hi = zh;
        return box;
    endfunction

    task automatic send_box(input t_box_in box);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= box;
        @(negedge i_clk);
        while (!in_taken) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!cfg_taken) @(negedge i_clk);
    endtask

    // Waits until the block is empty, then loads a whole transform.
    task automatic program_transform(input logic [CFG_W-1:0] dims, input logic [ROW_W-1:0] rx,
                                     input logic [ROW_W-1:0] ry, input logic [ROW_W-1:0] rz,
                                     input t_coord sx, input t_coord sy, input t_coord sz,
                                     input bit with_bad);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        if (with_bad) begin
            write_register(CFG_DIM, CFG_W'($urandom_range(1)));
            write_register(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
        end
        write_register(CFG_DIM, dims);
        write_register(CFG_ROW_X, CFG_W'(rx));
        write_register(CFG_ROW_Y, CFG_W'(ry));
        write_register(CFG_ROW_Z, CFG_W'(rz));
        write_register(CFG_SHIFT_X, CFG_W'(sx));
        write_register(CFG_SHIFT_Y, CFG_W'(sy));
        write_register(CFG_SHIFT_Z, CFG_W'(sz));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        logic [ROW_W-1:0] row_one;
        int               phase, n;
        row_one = ROW_W'(COEF_ONE);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity transform out of reset: exact pass-through, swapped bounds come out ordered
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MIN, 5, -5, -1, 1));
        send_box(make_box(-1, 1, 32'h0001_8000, -32'h0002_4000, 7, 7));

        // extreme coefficients and shifts; refused mode and unused index writes on the way
        program_transform(CFG_W'(DIM_3D), {3{COEF_NEG_MAX}}, {3{COEF_POS_MAX}}, {3{COEF_HALF}},
                          COORD_MIN, COORD_MAX, 0, 1'b1);
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        // half coefficients on z: rounding ties go up (1.5 -> 2, -1.5 -> -1)
        send_box(make_box(1, 1, 1, 1, 1, 1));
        send_box(make_box(-1, -1, -1, -1, -1, -1));
        send_box(make_box(-3, 3, 1, -1, 0, 1));

        // a mode value with high bits set selects 2D through its low bits; z is ignored
        program_transform(CFG_W'(6), rand_small_row(), rand_small_row(), rand_full_row(),
                          rand_span(1 << 20), rand_span(1 << 20), $urandom, 1'b0);
        send_box(make_box(0, 0, 0, 0, COORD_MIN, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 3, -3));
        send_box(make_box(-16, 16, 1 << 16, -(1 << 16), $urandom, $urandom));
        send_box(rand_box());

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: program_transform(CFG_W'(DIM_3D), row_one, row_one << COEF_W,
                                     row_one << (2 * COEF_W), rand_span(1 << 24),
                                     rand_span(1 << 24), rand_span(1 << 24), 1'b0);
                1: program_transform(CFG_W'(DIM_3D), rand_small_row(), rand_small_row(),
                                     rand_small_row(), rand_span(1 << 22), rand_span(1 << 22),
                                     rand_span(1 << 22), 1'b0);
                2: program_transform(CFG_W'(DIM_2D), rand_small_row(), rand_small_row(),
                                     rand_small_row(), rand_span(1 << 22), rand_span(1 << 22),
                                     rand_span(1 << 22), 1'b0);
                3: begin
                    // back-to-back requests with the receiver always ready
                    calm = 1'b1;
                    program_transform($urandom_range(1) ? CFG_W'(DIM_2D) : CFG_W'(DIM_3D),
                                      rand_full_row(), rand_full_row(), rand_full_row(),
                                      $urandom, $urandom, $urandom, 1'b1);
                end
                4: program_transform(CFG_W'(DIM_3D), {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}},
                                     {3{COEF_NEG_MAX}}, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
                5: program_transform(CFG_W'(DIM_2D), {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}},
                                     {3{COEF_POS_MAX}}, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
                6: program_transform(CFG_W'(DIM_3D), '0, '0, '0, $urandom, $urandom, $urandom,
                                     1'b0);
                default: program_transform(CFG_W'(DIM_3D), rand_full_row(), rand_small_row(),
                                           rand_full_row(), $urandom, rand_span(1 << 20),
                                           $urandom, 1'b1);
            endcase
            for (n = 0; n < PHASE_BOXES; n++)
                send_box(rand_box());
            calm = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Summary: %0d boxes checked under %0d register settings, %0d saturated",
                 result_count, settings_used, sat_count);
        $display("Covered 2D and 3D modes, refused mode writes, the unused index and full-range bounds");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
